### hdl/cpbt_pkg.sv
package cpbt_pkg;

  localparam int PAGE_SIZE   = 'h100;
  localparam int INDEX_W     = $clog2(PAGE_SIZE);
  localparam int CP_W        = 16;
  localparam int COUNT_WIDTH = 32;
  localparam int SEEN_W      = 32;

  localparam logic [7:0] DEFAULT_UNMAPPED = 8'h3F;  // '?'

  localparam logic [1:0] FUNC_LOAD_IN  = 2'd0;
  localparam logic [1:0] FUNC_LOAD_OUT = 2'd1;
  localparam logic [1:0] FUNC_XLATE    = 2'd2;

  localparam logic [0:0] REG_UNMAPPED = 1'b0;

  typedef struct packed {
    logic wr_in;        // write input page entry
    logic wr_out;       // write output page entry
    logic capture;      // translate accepted: latch index, read tables
    logic check;        // compare same-byte entry, update hit counter
    logic scan;         // step the output page scan
    logic emit_direct;
    logic emit_scan;
    logic emit_miss;
  } cmd_t;

  typedef struct packed {
    logic direct_hit;
    logic scan_hit;
    logic scan_last;
  } status_t;

  // Report a counter of up to 64 bits as a 32-bit value, saturating.
  function automatic logic [SEEN_W-1:0] seen_sat(input logic [COUNT_WIDTH-1:0] c);
    logic [63:0] w;
    w = 64'(c);
    if (w > 64'hFFFF_FFFF) return '1;
    return w[SEEN_W-1:0];
  endfunction

endpackage

### hdl/cpbt_ctrl.sv
module cpbt_ctrl
  import cpbt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [1:0] func,
  input  status_t    status,
  output cmd_t       cmd,
  output logic       busy
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_CHECK = 3'b010,
    S_SCAN  = 3'b100
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    case (state)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          case (func)
            FUNC_LOAD_IN:  cmd.wr_in  = 1'b1;
            FUNC_LOAD_OUT: cmd.wr_out = 1'b1;
            FUNC_XLATE: begin
              cmd.capture = 1'b1;
              state_next  = S_CHECK;
            end
            default: ;
          endcase
        end
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        if (status.direct_hit) begin
          cmd.emit_direct = 1'b1;
          state_next      = S_IDLE;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (status.scan_hit) begin
          cmd.emit_scan = 1'b1;
          state_next    = S_IDLE;
        end else if (status.scan_last) begin
          cmd.emit_miss = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

### hdl/cpbt_dp.sv
module cpbt_dp
  import cpbt_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  cmd_t                cmd,
  input  logic [INDEX_W-1:0]  byte_index,
  input  logic [CP_W-1:0]     table_value,
  input  logic [7:0]          unmapped_char,
  output status_t             status,
  output logic                done,
  output logic [7:0]          out_byte,
  output logic                mapped,
  output logic [CP_W-1:0]     code_point,
  output logic [SEEN_W-1:0]   seen_count
);

  logic [CP_W-1:0]        input_page  [PAGE_SIZE];
  logic [CP_W-1:0]        output_page [PAGE_SIZE];
  logic [COUNT_WIDTH-1:0] hit_count   [PAGE_SIZE];
  logic [PAGE_SIZE-1:0]   hit_valid;

  logic [CP_W-1:0]        ip_rd;
  logic [CP_W-1:0]        op_rd;
  logic [COUNT_WIDTH-1:0] hc_rd;
  logic                   hv_rd;

  logic [INDEX_W-1:0]     idx;
  logic [CP_W-1:0]        cp;
  logic [INDEX_W-1:0]     scan_addr;
  logic [INDEX_W-1:0]     cmp_idx;
  logic                   cmp_valid;
  logic [SEEN_W-1:0]      seen;

  logic [INDEX_W-1:0]     op_addr;
  logic [COUNT_WIDTH-1:0] cnt_cur;
  logic [COUNT_WIDTH-1:0] cnt_new;

  assign op_addr = cmd.capture ? byte_index : scan_addr;

  // Tables: one write, one registered read each.
  always_ff @(posedge clk) begin
    if (cmd.wr_in) begin
      input_page[byte_index] <= table_value;
    end
    if (cmd.capture) begin
      ip_rd <= input_page[byte_index];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_out) begin
      output_page[byte_index] <= table_value;
    end
    if (cmd.capture || cmd.scan) begin
      op_rd <= output_page[op_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.check) begin
      hit_count[idx] <= cnt_new;
    end
    if (cmd.capture) begin
      hc_rd <= hit_count[byte_index];
    end
  end

  // Unwritten counters read as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      hit_valid <= '0;
    end else if (cmd.check) begin
      hit_valid[idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      hv_rd <= hit_valid[byte_index];
    end
  end

  assign cnt_cur = hv_rd ? hc_rd : '0;
  assign cnt_new = (cnt_cur == '1) ? cnt_cur : cnt_cur + COUNT_WIDTH'(1);

  // Scan pipeline: an address is issued, and its entry is compared in the next cycle.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      idx <= byte_index;
    end
    if (cmd.check) begin
      cp        <= ip_rd;
      seen      <= seen_sat(cnt_new);
      scan_addr <= '0;
      cmp_valid <= 1'b0;
    end else if (cmd.scan) begin
      scan_addr <= scan_addr + INDEX_W'(1);
      cmp_idx   <= scan_addr;
      cmp_valid <= 1'b1;
    end
  end

  assign status.direct_hit = (op_rd == ip_rd);
  assign status.scan_hit   = cmp_valid && (op_rd == cp);
  assign status.scan_last  = cmp_valid && (cmp_idx == INDEX_W'(PAGE_SIZE - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.emit_direct || cmd.emit_scan || cmd.emit_miss;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_direct) begin
      out_byte   <= idx;
      mapped     <= 1'b1;
      code_point <= ip_rd;
      seen_count <= seen_sat(cnt_new);
    end else if (cmd.emit_scan) begin
      out_byte   <= cmp_idx;
      mapped     <= 1'b1;
      code_point <= cp;
      seen_count <= seen;
    end else if (cmd.emit_miss) begin
      out_byte   <= unmapped_char;
      mapped     <= 1'b0;
      code_point <= cp;
      seen_count <= seen;
    end
  end

endmodule

### hdl/code_page_byte_translator.sv
// Code page byte translator. A beat is taken when start is high and busy is
// low. Loads (func 0 input page, func 1 output page) raise no busy and give
// no result. A translate raises busy and returns one result beat, marked by
// done for a single cycle, that must be taken as it appears. When the output
// page holds the code point at the same byte, the result is decided in the
// check state; otherwise the output page is scanned one entry per cycle
// through its single read port until a match, or to its last entry when the
// code point is absent. A new beat may be started in the cycle done is shown.
// The replacement byte lives at APB address 0.
module code_page_byte_translator
  import cpbt_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          func,
  input  logic [INDEX_W-1:0]  byte_index,
  input  logic [CP_W-1:0]     table_value,
  output logic                done,
  output logic [7:0]          out_byte,
  output logic                mapped,
  output logic [CP_W-1:0]     code_point,
  output logic [SEEN_W-1:0]   seen_count,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  cmd_t       cmd;
  status_t    status;
  logic [7:0] unmapped_char;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      unmapped_char <= DEFAULT_UNMAPPED;
    end else if (psel && penable && pwrite && (paddr[2] == REG_UNMAPPED)) begin
      unmapped_char <= pwdata[7:0];
    end
  end

  assign prdata = (paddr[2] == REG_UNMAPPED) ? {24'd0, unmapped_char} : 32'd0;

  cpbt_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .func   (func),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  cpbt_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .byte_index    (byte_index),
    .table_value   (table_value),
    .unmapped_char (unmapped_char),
    .status        (status),
    .done          (done),
    .out_byte      (out_byte),
    .mapped        (mapped),
    .code_point    (code_point),
    .seen_count    (seen_count)
  );

endmodule

### hdl/cpbt_chk.sv
module cpbt_chk
  import cpbt_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic [1:0] func,
  input logic       done
);

  // A translate beat always occupies the block.
  a_xlate_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (func == FUNC_XLATE) |=> busy)
    else $error("translate beat did not raise busy");

  // Results come out only after the work has finished.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while busy");

  // Every translate ends in exactly one result beat.
  a_fell_done: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("translate finished without a result");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result beat repeated");

endmodule

bind code_page_byte_translator cpbt_chk u_cpbt_chk (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .func  (func),
  .done  (done)
);
